@@ sv/qmn_pkg.sv @@
package qmn_pkg;

   localparam int COMP_W          = 32;
   localparam int PROD_W          = 64;
   localparam int SUM_W           = 66;
   localparam int FRAC_W          = 16;
   localparam int P_W             = SUM_W - FRAC_W;
   localparam int V_W             = 31;
   localparam int SHIFT_MAX       = 18;
   localparam int SHIFT_W         = 5;
   localparam int SQ_W            = 2 * V_W;
   localparam int RAD_W           = 64;
   localparam int ROOT_W          = 32;
   localparam int REM_W           = ROOT_W + 2;
   localparam int NUM_W           = 48;
   localparam int DIV_W           = 32;
   localparam int QUO_W           = 17;
   localparam int LANES           = 4;
   localparam int TERMS           = 16;
   localparam int TOT_W           = 65;
   localparam int STEPS_PER_STAGE = 2;

   // term order: four terms per component, x, y, z, w
   localparam int A_SEL [TERMS] = '{0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 2, 3};
   localparam int B_SEL [TERMS] = '{3, 2, 1, 0, 2, 3, 0, 1, 1, 0, 3, 2, 0, 1, 2, 3};
   localparam logic [TERMS-1:0] TERM_NEG = 16'h7214;

   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);
   localparam logic signed [P_W-1:0]   P_MAX      = P_W'(64'sd2147483647);
   localparam logic signed [P_W-1:0]   P_MIN      = P_W'(-64'sd2147483648);
   localparam logic [P_W-1:0]          V_LIMIT    = P_W'(64'h8000_0000);
   localparam logic [COMP_W-1:0]       MAG_SAT    = 32'hFFFF_FFFF;

   typedef logic signed [COMP_W-1:0] comp_type;

   typedef struct packed {
      logic en;
      logic valid;
   } pipe_ctl_type;

   typedef struct packed {
      logic [LANES-1:0][V_W-1:0]    v;
      logic [LANES-1:0]             neg;
      logic [LANES-1:0][COMP_W-1:0] rraw;
      logic                         satraw;
      logic                         raw;
   } norm_side_type;

   typedef struct packed {
      logic [LANES-1:0]             neg;
      logic [LANES-1:0][COMP_W-1:0] rraw;
      logic                         satraw;
      logic                         raw;
      logic                         nzero;
   } div_side_type;

   typedef struct packed {
      logic [LANES-1:0][COMP_W-1:0] r;
      logic                         sat;
      logic                         carry;
   } mag_side_type;

endpackage

@@ sv/qmn_req_if.sv @@
interface qmn_req_if;
   import qmn_pkg::*;

   logic     valid;
   logic     ready;
   comp_type a_x;
   comp_type a_y;
   comp_type a_z;
   comp_type a_w;
   comp_type b_x;
   comp_type b_y;
   comp_type b_z;
   comp_type b_w;
   logic     keep_raw;

   modport source (output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, keep_raw,
                   input ready);
   modport sink (input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, keep_raw,
                 output ready);
endinterface

@@ sv/qmn_rsp_if.sv @@
interface qmn_rsp_if;
   import qmn_pkg::*;

   logic        valid;
   logic        ready;
   comp_type    r_x;
   comp_type    r_y;
   comp_type    r_z;
   comp_type    r_w;
   logic [31:0] magnitude;
   logic        saturated;

   modport source (output valid, r_x, r_y, r_z, r_w, magnitude, saturated, input ready);
   modport sink (input valid, r_x, r_y, r_z, r_w, magnitude, saturated, output ready);
endinterface

@@ sv/qmn_isqrt.sv @@
module qmn_isqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  qmn_pkg::pipe_ctl_type         ctl_in,
   input  logic [qmn_pkg::RAD_W-1:0]     radicand,
   input  logic [SIDE_W-1:0]             side_in,
   output logic                          out_valid,
   output logic [qmn_pkg::ROOT_W-1:0]    root,
   output logic [qmn_pkg::REM_W-1:0]     rem,
   output logic [SIDE_W-1:0]             side_out
);
   import qmn_pkg::*;

   localparam int STAGES = ROOT_W / STEPS_PER_STAGE;

   logic [RAD_W-1:0]  x_ff    [STAGES];
   logic [ROOT_W-1:0] root_ff [STAGES];
   logic [REM_W-1:0]  rem_ff  [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];
   logic [STAGES-1:0] valid_ff;

   logic [RAD_W-1:0]  x_in    [STAGES];
   logic [ROOT_W-1:0] root_in [STAGES];
   logic [REM_W-1:0]  rem_in  [STAGES];

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      logic [RAD_W-1:0]  x_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;

      if (g == 0) begin : g_first
         assign x_prev     = radicand;
         assign root_prev  = '0;
         assign rem_prev   = '0;
         assign side_prev  = side_in;
         assign valid_prev = ctl_in.valid;
      end else begin : g_next
         assign x_prev     = x_ff[g-1];
         assign root_prev  = root_ff[g-1];
         assign rem_prev   = rem_ff[g-1];
         assign side_prev  = side_ff[g-1];
         assign valid_prev = valid_ff[g-1];
      end

      // restoring digit recurrence, two radicand bits per step
      always_comb begin
         logic [REM_W-1:0] trial;
         x_in[g]    = x_prev;
         root_in[g] = root_prev;
         rem_in[g]  = rem_prev;
         trial      = '0;
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            rem_in[g] = {rem_in[g][REM_W-3:0], x_in[g][RAD_W-1 -: 2]};
            x_in[g]   = {x_in[g][RAD_W-3:0], 2'b00};
            trial     = {root_in[g], 2'b01};
            if (rem_in[g] >= trial) begin
               rem_in[g]  = rem_in[g] - trial;
               root_in[g] = {root_in[g][ROOT_W-2:0], 1'b1};
            end else begin
               root_in[g] = {root_in[g][ROOT_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (ctl_in.en) begin
            valid_ff[g] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl_in.en) begin
            x_ff[g]    <= x_in[g];
            root_ff[g] <= root_in[g];
            rem_ff[g]  <= rem_in[g];
            side_ff[g] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign root      = root_ff[STAGES-1];
   assign rem       = rem_ff[STAGES-1];
   assign side_out  = side_ff[STAGES-1];

`ifndef ASSERT_OFF
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (rem <= {1'b0, root, 1'b0}))
      else $error("isqrt remainder above twice the root");
`endif

endmodule

@@ sv/qmn_div.sv @@
module qmn_div #(
   parameter int SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  qmn_pkg::pipe_ctl_type         ctl_in,
   input  logic [qmn_pkg::NUM_W-1:0]     numer [qmn_pkg::LANES],
   input  logic [qmn_pkg::DIV_W-1:0]     divisor,
   input  logic [SIDE_W-1:0]             side_in,
   output logic                          out_valid,
   output logic [qmn_pkg::QUO_W-1:0]     quot [qmn_pkg::LANES],
   output logic [SIDE_W-1:0]             side_out
);
   import qmn_pkg::*;

   localparam int STAGES = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int DREM_W = DIV_W + 1;

   logic [DREM_W-1:0] rem_ff  [STAGES][LANES];
   logic [QUO_W-1:0]  low_ff  [STAGES][LANES];
   logic [QUO_W-1:0]  quo_ff  [STAGES][LANES];
   logic [DIV_W-1:0]  div_ff  [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];
   logic [STAGES-1:0] valid_ff;

   logic [DREM_W-1:0] rem_in  [STAGES][LANES];
   logic [QUO_W-1:0]  low_in  [STAGES][LANES];
   logic [QUO_W-1:0]  quo_in  [STAGES][LANES];

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      logic [DREM_W-1:0] rem_prev [LANES];
      logic [QUO_W-1:0]  low_prev [LANES];
      logic [QUO_W-1:0]  quo_prev [LANES];
      logic [DIV_W-1:0]  div_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;

      if (g == 0) begin : g_first
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign rem_prev[l] = DREM_W'(numer[l][NUM_W-1:QUO_W]);
            assign low_prev[l] = numer[l][QUO_W-1:0];
            assign quo_prev[l] = '0;
         end
         assign div_prev   = divisor;
         assign side_prev  = side_in;
         assign valid_prev = ctl_in.valid;
      end else begin : g_next
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign rem_prev[l] = rem_ff[g-1][l];
            assign low_prev[l] = low_ff[g-1][l];
            assign quo_prev[l] = quo_ff[g-1][l];
         end
         assign div_prev   = div_ff[g-1];
         assign side_prev  = side_ff[g-1];
         assign valid_prev = valid_ff[g-1];
      end

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            rem_in[g][l] = rem_prev[l];
            low_in[g][l] = low_prev[l];
            quo_in[g][l] = quo_prev[l];
            for (int j = 0; j < STEPS_PER_STAGE; j++) begin
               if (g * STEPS_PER_STAGE + j < QUO_W) begin
                  rem_in[g][l] = {rem_in[g][l][DREM_W-2:0], low_in[g][l][QUO_W-1]};
                  low_in[g][l] = {low_in[g][l][QUO_W-2:0], 1'b0};
                  if (rem_in[g][l] >= {1'b0, div_prev}) begin
                     rem_in[g][l] = rem_in[g][l] - {1'b0, div_prev};
                     quo_in[g][l] = {quo_in[g][l][QUO_W-2:0], 1'b1};
                  end else begin
                     quo_in[g][l] = {quo_in[g][l][QUO_W-2:0], 1'b0};
                  end
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (ctl_in.en) begin
            valid_ff[g] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl_in.en) begin
            for (int l = 0; l < LANES; l++) begin
               rem_ff[g][l] <= rem_in[g][l];
               low_ff[g][l] <= low_in[g][l];
               quo_ff[g][l] <= quo_in[g][l];
            end
            div_ff[g]  <= div_prev;
            side_ff[g] <= side_prev;
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         quot[l] = quo_ff[STAGES-1][l];
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign side_out  = side_ff[STAGES-1];

`ifndef ASSERT_OFF
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      out_valid && (div_ff[STAGES-1] != '0) |->
         (rem_ff[STAGES-1][0] < {1'b0, div_ff[STAGES-1]}) &&
         (rem_ff[STAGES-1][1] < {1'b0, div_ff[STAGES-1]}) &&
         (rem_ff[STAGES-1][2] < {1'b0, div_ff[STAGES-1]}) &&
         (rem_ff[STAGES-1][3] < {1'b0, div_ff[STAGES-1]}))
      else $error("divider remainder not below divisor");
`endif

endmodule

@@ sv/quaternion_multiply_normalize.sv @@
// Channel   | Dir | Handshake                 | Payload
// req_chan  | in  | valid / ready             | a_x..a_w, b_x..b_w (Q16.16), keep_raw
// rsp_chan  | out | valid / ready             | r_x..r_w (Q16.16), magnitude, saturated
//
// One request per cycle unless the output is held. Stages: 5 product/sum/shift,
// 16-stage root, 9-stage divider, 3 square/sum stages, 16-stage root, output.
// Latency is set by the two radix-4 square-root pipelines, two result bits a stage.
// Synchronous reset clears the valid bits only; no clearing pass.
// The whole pipeline advances whenever the output register is empty or taken;
// a held result freezes every stage, so nothing is lost or repeated.
module quaternion_multiply_normalize (
   input logic       clock,
   input logic       reset,
   qmn_req_if.sink   req_chan,
   qmn_rsp_if.source rsp_chan
);
   import qmn_pkg::*;

   logic         en;
   pipe_ctl_type sqa_ctl, div_ctl, sqb_ctl;

   // stage 1: sixteen partial products
   comp_type                  a_op [LANES];
   comp_type                  b_op [LANES];
   logic signed [PROD_W-1:0]  prod_in [TERMS];
   logic signed [PROD_W-1:0]  prod_ff [TERMS];
   logic                      raw1_ff, v1_ff;

   // stage 2: rounded component sums
   logic signed [P_W-1:0]     p_in [LANES];
   logic signed [P_W-1:0]     p_ff [LANES];
   logic                      raw2_ff, v2_ff;

   // stages 3 to 5: saturate / prescale, squares, sum of squares
   norm_side_type             side3_in, side3_ff, side4_ff, side5_ff;
   logic                      v3_ff, v4_ff, v5_ff;
   logic [SQ_W-1:0]           sq4_in [LANES];
   logic [SQ_W-1:0]           sq4_ff [LANES];
   logic [RAD_W-1:0]          ss5_in, ss5_ff;

   // norm root and divider
   logic                      sqa_valid;
   logic [ROOT_W-1:0]         sqa_root;
   norm_side_type             sqa_side;
   logic [NUM_W-1:0]          numer [LANES];
   div_side_type              div_side_in, div_side_out;
   logic                      div_valid;
   logic [QUO_W-1:0]          quot [LANES];

   // stages 7 to 9: returned components, their squares, the total
   comp_type                  r7_in [LANES];
   comp_type                  r7_ff [LANES];
   logic                      sat7_ff, v7_ff;
   logic [RAD_W-1:0]          msq8_in [LANES];
   logic [RAD_W-1:0]          msq8_ff [LANES];
   comp_type                  r8_ff [LANES];
   logic                      sat8_ff, v8_ff;
   logic [TOT_W-1:0]          tot9_in;
   logic [RAD_W-1:0]          tot9_ff;
   mag_side_type              side9_ff;
   logic                      v9_ff;

   // magnitude root and output register
   logic                      sqb_valid;
   logic [ROOT_W-1:0]         sqb_root;
   logic [REM_W-1:0]          sqb_rem;
   mag_side_type              sqb_side;
   logic [ROOT_W:0]           mag_round;
   logic [COMP_W-1:0]         mag_in;
   logic                      sat_in;
   comp_type                  out_r_ff [LANES];
   logic [COMP_W-1:0]         out_mag_ff;
   logic                      out_sat_ff, out_v_ff;

   assign en             = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // ---------------- stage 1 ----------------
   assign a_op = '{req_chan.a_x, req_chan.a_y, req_chan.a_z, req_chan.a_w};
   assign b_op = '{req_chan.b_x, req_chan.b_y, req_chan.b_z, req_chan.b_w};

   always_comb begin
      for (int i = 0; i < TERMS; i++) begin
         prod_in[i] = PROD_W'(a_op[A_SEL[i]]) * PROD_W'(b_op[B_SEL[i]]);
      end
   end

   // ---------------- stage 2 ----------------
   // exact sum of the four Q32.32 terms, rounded half up to Q34.16
   always_comb begin
      logic signed [SUM_W-1:0] acc;
      logic signed [SUM_W-1:0] term;
      acc  = '0;
      term = '0;
      for (int c = 0; c < LANES; c++) begin
         acc = ROUND_HALF;
         for (int t = 0; t < LANES; t++) begin
            term = SUM_W'(prod_ff[c * LANES + t]);
            acc  = TERM_NEG[c * LANES + t] ? acc - term : acc + term;
         end
         p_in[c] = acc[SUM_W-1:FRAC_W];
      end
   end

   // ---------------- stage 3 ----------------
   // raw path clips; normalize path drops low bits until all fit in 31 bits
   always_comb begin
      logic [P_W-1:0]     mag [LANES];
      logic [P_W-1:0]     mag_or;
      logic [P_W-1:0]     shifted;
      logic [SHIFT_W-1:0] shift;
      mag_or          = '0;
      shift           = '0;
      shifted         = '0;
      side3_in.satraw = 1'b0;
      side3_in.raw    = raw2_ff;
      for (int c = 0; c < LANES; c++) begin
         mag[c]           = p_ff[c][P_W-1] ? P_W'(-p_ff[c]) : P_W'(p_ff[c]);
         mag_or           = mag_or | mag[c];
         side3_in.neg[c]  = p_ff[c][P_W-1];
         if (p_ff[c] > P_MAX) begin
            side3_in.rraw[c] = P_MAX[COMP_W-1:0];
            side3_in.satraw  = 1'b1;
         end else if (p_ff[c] < P_MIN) begin
            side3_in.rraw[c] = P_MIN[COMP_W-1:0];
            side3_in.satraw  = 1'b1;
         end else begin
            side3_in.rraw[c] = p_ff[c][COMP_W-1:0];
         end
      end
      for (int s = SHIFT_MAX; s >= 0; s--) begin
         if ((mag_or >> s) < V_LIMIT) begin
            shift = SHIFT_W'(s);
         end
      end
      for (int c = 0; c < LANES; c++) begin
         shifted       = mag[c] >> shift;
         side3_in.v[c] = shifted[V_W-1:0];
      end
   end

   // ---------------- stages 4, 5 ----------------
   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         sq4_in[c] = SQ_W'(side3_ff.v[c]) * SQ_W'(side3_ff.v[c]);
      end
   end

   always_comb begin
      ss5_in = '0;
      for (int c = 0; c < LANES; c++) begin
         ss5_in = ss5_in + RAD_W'(sq4_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v7_ff <= div_valid;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
         out_v_ff <= sqb_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         raw1_ff  <= req_chan.keep_raw;
         p_ff     <= p_in;
         raw2_ff  <= raw1_ff;
         side3_ff <= side3_in;
         sq4_ff   <= sq4_in;
         side4_ff <= side3_ff;
         ss5_ff   <= ss5_in;
         side5_ff <= side4_ff;
      end
   end

   // ---------------- norm root ----------------
   assign sqa_ctl = '{en: en, valid: v5_ff};

   qmn_isqrt #(.SIDE_W($bits(norm_side_type))) u_norm_root (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (sqa_ctl),
      .radicand  (ss5_ff),
      .side_in   (side5_ff),
      .out_valid (sqa_valid),
      .root      (sqa_root),
      .rem       (),
      .side_out  (sqa_side)
   );

   // ---------------- divider: round(v * 2^16 / n) ----------------
   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         numer[c] = (NUM_W'(sqa_side.v[c]) << FRAC_W) + NUM_W'(sqa_root >> 1);
      end
      div_side_in.neg    = sqa_side.neg;
      div_side_in.rraw   = sqa_side.rraw;
      div_side_in.satraw = sqa_side.satraw;
      div_side_in.raw    = sqa_side.raw;
      div_side_in.nzero  = (sqa_root == '0);
   end

   assign div_ctl = '{en: en, valid: sqa_valid};

   qmn_div #(.SIDE_W($bits(div_side_type))) u_scale_div (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (div_ctl),
      .numer     (numer),
      .divisor   (sqa_root),
      .side_in   (div_side_in),
      .out_valid (div_valid),
      .quot      (quot),
      .side_out  (div_side_out)
   );

   // ---------------- stage 7: pick returned components ----------------
   always_comb begin
      logic [COMP_W-1:0] qx;
      qx = '0;
      for (int c = 0; c < LANES; c++) begin
         qx = COMP_W'(quot[c]);
         if (div_side_out.raw) begin
            r7_in[c] = div_side_out.rraw[c];
         end else if (div_side_out.nzero) begin
            r7_in[c] = '0;        // zero product passes through
         end else begin
            r7_in[c] = div_side_out.neg[c] ? -qx : qx;
         end
      end
   end

   // ---------------- stages 8, 9: squares of returned values ----------------
   always_comb begin
      logic [COMP_W-1:0] abs_r;
      abs_r = '0;
      for (int c = 0; c < LANES; c++) begin
         abs_r      = r7_ff[c][COMP_W-1] ? -r7_ff[c] : r7_ff[c];
         msq8_in[c] = RAD_W'(abs_r) * RAD_W'(abs_r);
      end
   end

   always_comb begin
      tot9_in = '0;
      for (int c = 0; c < LANES; c++) begin
         tot9_in = tot9_in + TOT_W'(msq8_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r7_ff          <= r7_in;
         sat7_ff        <= div_side_out.raw && div_side_out.satraw;
         msq8_ff        <= msq8_in;
         r8_ff          <= r7_ff;
         sat8_ff        <= sat7_ff;
         tot9_ff        <= tot9_in[RAD_W-1:0];
         side9_ff.carry <= tot9_in[RAD_W];   // all four at -2^31
         side9_ff.sat   <= sat8_ff;
         for (int c = 0; c < LANES; c++) begin
            side9_ff.r[c] <= r8_ff[c];
         end
      end
   end

   // ---------------- magnitude root ----------------
   assign sqb_ctl = '{en: en, valid: v9_ff};

   qmn_isqrt #(.SIDE_W($bits(mag_side_type))) u_mag_root (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (sqb_ctl),
      .radicand  (tot9_ff),
      .side_in   (side9_ff),
      .out_valid (sqb_valid),
      .root      (sqb_root),
      .rem       (sqb_rem),
      .side_out  (sqb_side)
   );

   // ---------------- output: round root to nearest, clip ----------------
   always_comb begin
      mag_round = {1'b0, sqb_root} + (ROOT_W + 1)'(sqb_rem > REM_W'(sqb_root));
      if (sqb_side.carry || mag_round[ROOT_W]) begin
         mag_in = MAG_SAT;
         sat_in = 1'b1;
      end else begin
         mag_in = mag_round[COMP_W-1:0];
         sat_in = sqb_side.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < LANES; c++) begin
            out_r_ff[c] <= sqb_side.r[c];
         end
         out_mag_ff <= mag_in;
         out_sat_ff <= sat_in;
      end
   end

   assign rsp_chan.valid     = out_v_ff;
   assign rsp_chan.r_x       = out_r_ff[0];
   assign rsp_chan.r_y       = out_r_ff[1];
   assign rsp_chan.r_z       = out_r_ff[2];
   assign rsp_chan.r_w       = out_r_ff[3];
   assign rsp_chan.magnitude = out_mag_ff;
   assign rsp_chan.saturated = out_sat_ff;

`ifndef ASSERT_OFF
   a_sat_cause: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_sat_ff |->
         (out_mag_ff == MAG_SAT) ||
         (out_r_ff[0] == P_MAX[COMP_W-1:0]) || (out_r_ff[0] == P_MIN[COMP_W-1:0]) ||
         (out_r_ff[1] == P_MAX[COMP_W-1:0]) || (out_r_ff[1] == P_MIN[COMP_W-1:0]) ||
         (out_r_ff[2] == P_MAX[COMP_W-1:0]) || (out_r_ff[2] == P_MIN[COMP_W-1:0]) ||
         (out_r_ff[3] == P_MAX[COMP_W-1:0]) || (out_r_ff[3] == P_MIN[COMP_W-1:0]))
      else $error("saturated flag without a clipped value");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_v_ff && !v1_ff && !v9_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule
